FILE: src/rtspfr_pkg.sv
package rtspfr_pkg;

	localparam int PulseW    = 16;
	localparam int FrameBits = 56;
	localparam int BitCntW   = $clog2(FrameBits + 1);
	localparam int NumRegs   = 8;
	localparam int RegIdxW   = $clog2(NumRegs);
	localparam int AddrW     = RegIdxW + 2;
	localparam int DataW     = 32;

	localparam logic [2:0] SyncNeeded = 3'd4;
	localparam logic [2:0] SyncSat    = 3'd7;

	// Register indexes
	localparam logic [RegIdxW-1:0] REG_HW_SYNC_MIN  = 3'd0;
	localparam logic [RegIdxW-1:0] REG_HW_SYNC_MAX  = 3'd1;
	localparam logic [RegIdxW-1:0] REG_SW_SYNC_MIN  = 3'd2;
	localparam logic [RegIdxW-1:0] REG_SW_SYNC_MAX  = 3'd3;
	localparam logic [RegIdxW-1:0] REG_HALF_SYM_MIN = 3'd4;
	localparam logic [RegIdxW-1:0] REG_HALF_SYM_MAX = 3'd5;
	localparam logic [RegIdxW-1:0] REG_FULL_SYM_MIN = 3'd6;
	localparam logic [RegIdxW-1:0] REG_FULL_SYM_MAX = 3'd7;

	// Default windows: nominal widths of 2416, 4550, 604 and 1208 us, +/-30 percent.
	localparam logic [PulseW-1:0] HW_SYNC_MIN_RST  = 16'd1691;
	localparam logic [PulseW-1:0] HW_SYNC_MAX_RST  = 16'd3140;
	localparam logic [PulseW-1:0] SW_SYNC_MIN_RST  = 16'd3185;
	localparam logic [PulseW-1:0] SW_SYNC_MAX_RST  = 16'd5915;
	localparam logic [PulseW-1:0] HALF_SYM_MIN_RST = 16'd422;
	localparam logic [PulseW-1:0] HALF_SYM_MAX_RST = 16'd785;
	localparam logic [PulseW-1:0] FULL_SYM_MIN_RST = 16'd845;
	localparam logic [PulseW-1:0] FULL_SYM_MAX_RST = 16'd1570;

	// Receiver status codes
	localparam logic [1:0] ST_WAIT = 2'd0;
	localparam logic [1:0] ST_RECV = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// Key nibbles and classes
	localparam logic [3:0] KEY_MY   = 4'h1;
	localparam logic [3:0] KEY_UP   = 4'h2;
	localparam logic [3:0] KEY_DOWN = 4'h4;
	localparam logic [3:0] KEY_PROG = 4'h8;

	localparam logic [2:0] CLS_MY      = 3'd0;
	localparam logic [2:0] CLS_UP      = 3'd1;
	localparam logic [2:0] CLS_DOWN    = 3'd2;
	localparam logic [2:0] CLS_PROG    = 3'd3;
	localparam logic [2:0] CLS_UNKNOWN = 3'd4;

	typedef struct packed {
		logic [PulseW-1:0] pulse_us;
	} pulse_t;

	typedef struct packed {
		logic [1:0]  rx_status;
		logic [3:0]  key_code;
		logic [2:0]  key_class;
		logic        checksum_ok;
		logic [15:0] seq_code;
		logic [23:0] remote_address;
	} frame_t;

	function automatic logic in_win(input logic [PulseW-1:0] p,
		input logic [PulseW-1:0] lo, input logic [PulseW-1:0] hi);
		return (p > lo) && (p < hi);
	endfunction

	function automatic logic [2:0] key_class_of(input logic [3:0] key);
		logic [2:0] cls;
		case (key)
			KEY_MY:   cls = CLS_MY;
			KEY_UP:   cls = CLS_UP;
			KEY_DOWN: cls = CLS_DOWN;
			KEY_PROG: cls = CLS_PROG;
			default:  cls = CLS_UNKNOWN;
		endcase
		return cls;
	endfunction

endpackage

FILE: src/rtspfr_if.sv
interface rtspfr_pulse_if;
	logic              valid;
	logic              ready;
	rtspfr_pkg::pulse_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rtspfr_frame_if;
	logic              valid;
	logic              ready;
	rtspfr_pkg::frame_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/rts_pulse_frame_receiver.sv
// Pulse-length frame receiver for a Manchester-coded rolling-code remote.
// Each beat on the pulse channel carries one measured level length in
// microseconds and yields exactly one beat on the frame channel with the
// receiver status; when the 56th data bit arrives, the status reads frame
// complete and the beat carries the key nibble and class, the checksum flag,
// the rolling code and the 24-bit address. One pulse is taken every clock
// cycle unless a result waits untaken in the output register: the window
// compares, bit assembly and unchaining all happen in the cycle the pulse
// is accepted, and the result sits in an output register, so a pulse is
// still accepted while the previous result is being taken. The eight timing
// windows are programmed over the APB port (register i at byte address 4*i,
// 16 bits) and must only be changed while no pulse is in flight.
module rts_pulse_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	rtspfr_pulse_if.sink                  pulse,
	rtspfr_frame_if.source                frame,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rtspfr_pkg::AddrW-1:0]  paddr,
	input  logic [rtspfr_pkg::DataW-1:0]  pwdata,
	output logic [rtspfr_pkg::DataW-1:0]  prdata,
	output logic                          pready
);

	localparam int PW = rtspfr_pkg::PulseW;
	localparam int FB = rtspfr_pkg::FrameBits;
	localparam int BW = rtspfr_pkg::BitCntW;

	logic [PW-1:0] cfg_q [rtspfr_pkg::NumRegs];

	logic                               recv_q, recv_d;
	logic [2:0]                         sync_q, sync_d;
	logic [BW-1:0]                      bits_q, bits_d;
	logic                               last_q, last_d;
	logic                               half_q, half_d;
	logic [FB-1:0]                      pay_q, pay_d;
	logic                               out_valid_q;
	rtspfr_pkg::frame_t                 out_data_q;
	rtspfr_pkg::frame_t                 result;

	logic                               accept;
	logic                               cfg_wr;
	logic [rtspfr_pkg::RegIdxW-1:0]     reg_idx;
	logic                               hw_hit, sw_hit, half_hit, full_hit;
	logic                               store;
	logic                               done;
	logic [7:0]                         raw [7];
	logic [7:0]                         clr [7];
	logic [3:0]                         ck;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[rtspfr_pkg::AddrW-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = {{(rtspfr_pkg::DataW - PW){1'b0}}, cfg_q[reg_idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[rtspfr_pkg::REG_HW_SYNC_MIN]  <= rtspfr_pkg::HW_SYNC_MIN_RST;
			cfg_q[rtspfr_pkg::REG_HW_SYNC_MAX]  <= rtspfr_pkg::HW_SYNC_MAX_RST;
			cfg_q[rtspfr_pkg::REG_SW_SYNC_MIN]  <= rtspfr_pkg::SW_SYNC_MIN_RST;
			cfg_q[rtspfr_pkg::REG_SW_SYNC_MAX]  <= rtspfr_pkg::SW_SYNC_MAX_RST;
			cfg_q[rtspfr_pkg::REG_HALF_SYM_MIN] <= rtspfr_pkg::HALF_SYM_MIN_RST;
			cfg_q[rtspfr_pkg::REG_HALF_SYM_MAX] <= rtspfr_pkg::HALF_SYM_MAX_RST;
			cfg_q[rtspfr_pkg::REG_FULL_SYM_MIN] <= rtspfr_pkg::FULL_SYM_MIN_RST;
			cfg_q[rtspfr_pkg::REG_FULL_SYM_MAX] <= rtspfr_pkg::FULL_SYM_MAX_RST;
		end else if (cfg_wr) begin
			cfg_q[reg_idx] <= pwdata[PW-1:0];
		end
	end

	// Handshake: the output register frees up in the same cycle it is taken.
	assign pulse.ready = !out_valid_q || frame.ready;
	assign accept      = pulse.valid && pulse.ready;
	assign frame.valid = out_valid_q;
	assign frame.data  = out_data_q;

	assign hw_hit   = rtspfr_pkg::in_win(pulse.data.pulse_us,
		cfg_q[rtspfr_pkg::REG_HW_SYNC_MIN], cfg_q[rtspfr_pkg::REG_HW_SYNC_MAX]);
	assign sw_hit   = rtspfr_pkg::in_win(pulse.data.pulse_us,
		cfg_q[rtspfr_pkg::REG_SW_SYNC_MIN], cfg_q[rtspfr_pkg::REG_SW_SYNC_MAX]);
	assign half_hit = rtspfr_pkg::in_win(pulse.data.pulse_us,
		cfg_q[rtspfr_pkg::REG_HALF_SYM_MIN], cfg_q[rtspfr_pkg::REG_HALF_SYM_MAX]);
	assign full_hit = rtspfr_pkg::in_win(pulse.data.pulse_us,
		cfg_q[rtspfr_pkg::REG_FULL_SYM_MIN], cfg_q[rtspfr_pkg::REG_FULL_SYM_MAX]);

	// Next-state logic for one pulse.
	always_comb begin
		recv_d = recv_q;
		sync_d = sync_q;
		bits_d = bits_q;
		last_d = last_q;
		half_d = half_q;
		pay_d  = pay_q;
		store  = 1'b0;
		if (!recv_q) begin
			if (hw_hit) begin
				if (sync_q < rtspfr_pkg::SyncSat) begin
					sync_d = sync_q + 3'd1;
				end
			end else if (sw_hit && sync_q >= rtspfr_pkg::SyncNeeded) begin
				recv_d = 1'b1;
				bits_d = '0;
				last_d = 1'b0;
				half_d = 1'b0;
				pay_d  = '0;
			end else begin
				sync_d = '0;
			end
		end else begin
			if (full_hit && !half_q) begin
				last_d = !last_q;
				store  = 1'b1;
			end else if (half_hit) begin
				half_d = !half_q;
				store  = half_q;
			end else begin
				sync_d = '0;
				recv_d = 1'b0;
			end
		end
		// The first bit of a frame ends up in the top position after 56 shifts.
		if (store && bits_q < BW'(FB)) begin
			pay_d  = {pay_q[FB-2:0], last_d};
			bits_d = bits_q + BW'(1);
		end
		done = recv_d && (bits_d >= BW'(FB));
		if (done) begin
			recv_d = 1'b0;
		end
	end

	// Undo the byte chaining and fold all nibbles into the checksum.
	always_comb begin
		for (int i = 0; i < 7; i++) begin
			raw[i] = pay_d[FB-1-8*i -: 8];
		end
		clr[0] = raw[0];
		for (int i = 1; i < 7; i++) begin
			clr[i] = raw[i] ^ raw[i-1];
		end
		ck = '0;
		for (int i = 0; i < 7; i++) begin
			ck = ck ^ clr[i][7:4] ^ clr[i][3:0];
		end
	end

	always_comb begin
		result = '0;
		if (done) begin
			result.rx_status      = rtspfr_pkg::ST_DONE;
			result.key_code       = clr[1][7:4];
			result.key_class      = rtspfr_pkg::key_class_of(clr[1][7:4]);
			result.checksum_ok    = (ck == 4'h0);
			result.seq_code       = {clr[2], clr[3]};
			result.remote_address = {clr[4], clr[5], clr[6]};
		end else if (recv_d) begin
			result.rx_status = rtspfr_pkg::ST_RECV;
		end else begin
			result.rx_status = rtspfr_pkg::ST_WAIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q      <= 1'b0;
			sync_q      <= '0;
			bits_q      <= '0;
			last_q      <= 1'b0;
			half_q      <= 1'b0;
			pay_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			recv_q      <= recv_d;
			sync_q      <= sync_d;
			bits_q      <= bits_d;
			last_q      <= last_d;
			half_q      <= half_d;
			pay_q       <= pay_d;
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

endmodule
